@@ hdl/umidi_pkg.sv @@
// Shared types and constants for the USB-MIDI event packet parser.
`default_nettype none

package umidi_pkg;

    // Code index numbers (low nibble of the packet header)
    localparam logic [3:0] CIN_SYSEX_START = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;
    localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
    localparam logic [3:0] CIN_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

    // SysEx framing bytes
    localparam logic [7:0] SYSEX_BEGIN = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    // Result event kinds
    localparam logic [2:0] KIND_NOTE_OFF    = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON     = 3'd1;
    localparam logic [2:0] KIND_CTRL_CHANGE = 3'd2;
    localparam logic [2:0] KIND_REALTIME    = 3'd3;
    localparam logic [2:0] KIND_SYSEX       = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;   // latch the incoming packet
        logic       clr_fill;  // SysEx start: empty the buffer
        logic       app_en;    // append step for app_slot
        logic [1:0] app_slot;  // 0 first_byte, 1 second_byte, 2 third_byte
        logic       k_clr;     // rewind the run read pointer
        logic       ld_event;  // load a channel/realtime event into the output
        logic       ld_marker; // load an empty SysEx marker into the output
        logic       ld_sysex;  // load the stored byte at the read pointer
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_event;    // packet gives one channel or realtime event
        logic has_append;  // packet appends at least one byte
        logic do_emit;     // packet is a valid SysEx end
        logic fill_zero;   // buffer holds nothing
        logic k_last;      // read pointer is at the last stored byte
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/umidi_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module umidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/umidi_ctrl.sv @@
// Control state machine for the USB-MIDI event packet parser.
`default_nettype none

module umidi_ctrl
    import umidi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_MARKER = 3'd4;
    localparam logic [2:0] S_EVENT  = 3'd5;
    localparam logic [2:0] S_RD     = 3'd6;
    localparam logic [2:0] S_LOAD   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_slot, n_slot;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        o_cmd   = '0;
        o_cmd.app_slot = r_slot;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_slot = 2'd0;
                if (i_sts.is_event) begin
                    n_state = S_EVENT;
                end else if (i_sts.has_append) begin
                    // clear only takes effect for a start packet with 0xF0
                    o_cmd.clr_fill = 1'b1;
                    n_state        = S_APPEND;
                end else if (i_sts.do_emit) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_APPEND: begin
                o_cmd.app_en = 1'b1;
                n_slot       = r_slot + 2'd1;
                if (r_slot == 2'd2) begin
                    n_state = i_sts.do_emit ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.k_clr = 1'b1;
                n_state     = i_sts.fill_zero ? S_MARKER : S_RD;
            end
            S_MARKER: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_marker = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EVENT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_event = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD: begin
                // read data for the pointer arrives next cycle
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_sysex = 1'b1;
                    n_state        = i_sts.k_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

endmodule

`default_nettype wire

@@ hdl/umidi_dp.sv @@
// Datapath: packet capture, SysEx buffer, run pointer and output register.
`default_nettype none

module umidi_dp
    import umidi_pkg::*;
#(
    parameter int SYSEX_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_header,
    input  wire logic [7:0] i_first_byte,
    input  wire logic [7:0] i_second_byte,
    input  wire logic [7:0] i_third_byte,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_event_kind,
    output logic [3:0]      o_channel,
    output logic [7:0]      o_data_one,
    output logic [7:0]      o_data_two,
    output logic [6:0]      o_message_length,
    output logic            o_last
);

    localparam int ADDR_W = $clog2(SYSEX_DEPTH);
    localparam int FILL_W = $clog2(SYSEX_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SYSEX_DEPTH);

    // Captured packet
    logic [3:0] r_code;
    logic [7:0] r_b1, r_b2, r_b3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= i_header[3:0];
            r_b1   <= i_first_byte;
            r_b2   <= i_second_byte;
            r_b3   <= i_third_byte;
        end
    end

    // Packet decode
    logic       start_clr;
    logic       end1_ok, end2_ok, end3_ok;
    logic [3:0] app_mask;

    assign start_clr = (r_code == CIN_SYSEX_START) && (r_b1 == SYSEX_BEGIN);
    assign end1_ok   = (r_code == CIN_SYSEX_END1) && (r_b1 == SYSEX_END);
    assign end2_ok   = (r_code == CIN_SYSEX_END2) && (r_b2 == SYSEX_END);
    assign end3_ok   = (r_code == CIN_SYSEX_END3) && (r_b3 == SYSEX_END);

    always_comb begin
        app_mask = 4'b0000;
        if (r_code == CIN_SYSEX_START) begin
            app_mask = {2'b01, 1'b1, !start_clr};
        end else if (end2_ok) begin
            app_mask = 4'b0001;
        end else if (end3_ok) begin
            app_mask = 4'b0011;
        end
    end

    // SysEx fill count and append write
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              buf_full;
    logic              wr_en;
    logic [7:0]        wr_byte;

    assign buf_full = (r_fill == FILL_MAX);
    assign wr_en    = i_cmd.app_en && app_mask[i_cmd.app_slot] && !buf_full;

    always_comb begin
        case (i_cmd.app_slot)
            2'd0:    wr_byte = r_b1;
            2'd1:    wr_byte = r_b2;
            default: wr_byte = r_b3;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.clr_fill && start_clr) begin
            n_fill = '0;
        end else if (wr_en) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // Run read pointer
    logic [ADDR_W-1:0] r_k, n_k;
    logic              k_last;

    assign k_last = ((FILL_W'(r_k) + FILL_W'(1)) == r_fill);

    always_comb begin
        n_k = r_k;
        if (i_cmd.k_clr) begin
            n_k = '0;
        end else if (i_cmd.ld_sysex) begin
            n_k = r_k + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_k    <= '0;
        end else begin
            r_fill <= n_fill;
            r_k    <= n_k;
        end
    end

    // SysEx buffer
    logic [7:0] rd_byte;

    umidi_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_DEPTH)
    ) u_sysex_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (wr_byte),
        .i_raddr (r_k),
        .o_rdata (rd_byte)
    );

    // Event payload from the captured packet
    logic [2:0] ev_kind;
    logic [3:0] ev_chan;
    logic [7:0] ev_d1, ev_d2;

    always_comb begin
        ev_kind = KIND_REALTIME;
        ev_chan = r_b1[3:0];
        ev_d1   = r_b2;
        ev_d2   = r_b3;
        case (r_code)
            CIN_NOTE_OFF:    ev_kind = KIND_NOTE_OFF;
            CIN_NOTE_ON:     ev_kind = (r_b3 == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            CIN_CTRL_CHANGE: ev_kind = KIND_CTRL_CHANGE;
            default: begin
                ev_kind = KIND_REALTIME;
                ev_chan = 4'd0;
                ev_d1   = r_b1;
                ev_d2   = 8'd0;
            end
        endcase
    end

    // Output register
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic ld_any;

    assign out_free = !r_out_valid || !i_out_stall;
    assign ld_any   = i_cmd.ld_event || i_cmd.ld_marker || i_cmd.ld_sysex;

    always_comb begin
        if (ld_any) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_event) begin
            o_event_kind     <= ev_kind;
            o_channel        <= ev_chan;
            o_data_one       <= ev_d1;
            o_data_two       <= ev_d2;
            o_message_length <= 7'd0;
            o_last           <= 1'b1;
        end else if (i_cmd.ld_marker) begin
            o_event_kind     <= KIND_SYSEX;
            o_channel        <= 4'd0;
            o_data_one       <= 8'd0;
            o_data_two       <= 8'd0;
            o_message_length <= 7'd0;
            o_last           <= 1'b1;
        end else if (i_cmd.ld_sysex) begin
            o_event_kind     <= KIND_SYSEX;
            o_channel        <= 4'd0;
            o_data_one       <= rd_byte;
            o_data_two       <= 8'd0;
            o_message_length <= 7'(r_fill);
            o_last           <= k_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.is_event   = r_code inside {CIN_NOTE_OFF, CIN_NOTE_ON,
                                          CIN_CTRL_CHANGE, CIN_SINGLE_BYTE};
        o_sts.has_append = (app_mask != 4'b0000);
        o_sts.do_emit    = end1_ok || end2_ok || end3_ok;
        o_sts.fill_zero  = (r_fill == '0);
        o_sts.k_last     = k_last;
        o_sts.out_free   = out_free;
    end

endmodule

`default_nettype wire

@@ hdl/usb_midi_packet_parser.sv @@
// USB-MIDI event packet parser: top level.
//
// Input channel: one 4-byte USB-MIDI event packet per transaction (header and
// three bytes), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one result per transaction on o_out_valid / i_out_stall.
// Note, control change and single-byte packets give one result; a valid SysEx
// end gives the buffered bytes as a run (last set on the final byte), or one
// empty marker when the buffer is empty. SysEx start/continue packets only
// store bytes.
// Timing: the controller handles one packet at a time. An event packet is
// captured, decoded and then loaded into the output register once that is
// free. A SysEx start/continue packet is decoded and then written in three
// store-write slots on the single write port; a run takes each buffered byte
// through a registered RAM read and then an output load, which waits while
// the receiver stalls.
// The output register keeps a finished result while the receiver stalls; the
// parser waits only when it has a new result and that register is still full.
// Reset clears the controller, the buffer fill count, the run read pointer and the output valid.
// Buffer contents are not cleared; only written entries are ever read.
`default_nettype none

module usb_midi_packet_parser
    import umidi_pkg::*;
#(
    parameter int SYSEX_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_header,
    input  wire logic [7:0] i_first_byte,
    input  wire logic [7:0] i_second_byte,
    input  wire logic [7:0] i_third_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_event_kind,
    output logic [3:0]      o_channel,
    output logic [7:0]      o_data_one,
    output logic [7:0]      o_data_two,
    output logic [6:0]      o_message_length,
    output logic            o_last
);

    t_cmd cmd;
    t_sts sts;

    umidi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    umidi_dp #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_header         (i_header),
        .i_first_byte     (i_first_byte),
        .i_second_byte    (i_second_byte),
        .i_third_byte     (i_third_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_event_kind     (o_event_kind),
        .o_channel        (o_channel),
        .o_data_one       (o_data_one),
        .o_data_two       (o_data_two),
        .o_message_length (o_message_length),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
